>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> hw/rtl/mexp_pkg.sv
// Package for the modular exponentiation unit: widths and sequencer codes.
`default_nettype none
package mexp_pkg;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned WORDS_DEF    = 8;
    localparam int unsigned TDATA_IN_W   = 96;
    localparam int unsigned TDATA_OUT_W  = 32;

    // multiplier sequencer commands
    typedef struct packed {
        logic start;
        logic sel_src_x;   // multiplier operand: 1 = x (square), 0 = acc
    } t_mul_cmd;
endpackage
`default_nettype wire

>>> hw/rtl/modular_exponentiation_unit.sv
// Top level: right-to-left binary modular exponentiation over streamed words.
// After the last word, words past those loaded are cleared; a zero modulus then sends
// zero words flagged in tuser, else the base is reduced mod m, each exponent bit takes a
// multiply into acc if set and a squaring of x; WORDS words are output, subject to stalls.
// Throughput: one run at a time; input is held off from the last word until
// the final result word is taken. Reset (synchronous, active low) clears the sequencer.
`default_nettype none
`include "assert_macros.svh"
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int unsigned WORDS = WORDS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: base_word[31:0], exponent_word[63:32], modulus_word[95:64]
    input  wire [TDATA_IN_W-1:0]   s_axis_tdata,
    input  wire                    s_axis_tlast,   // last_word
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // tdata: result_word[31:0]
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,   // modulus_error
    output logic                   m_axis_tlast    // last_result
);
    localparam int unsigned N  = WORDS * DATA_W;
    localparam int unsigned CW = $clog2(WORDS + 1);
    localparam int unsigned BW = $clog2(N + 1);

    localparam logic [2:0] S_LOAD = 3'd0, S_RED = 3'd1, S_MUL = 3'd2,
                           S_SQR = 3'd3, S_WAIT = 3'd4, S_OUT = 3'd5;

    logic [2:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_b, r_e, r_m, r_x, r_acc;
    logic [BW-1:0] r_bits;
    logic          r_err, r_wait_sqr, r_mstart;
    t_mul_cmd      w_cmd;
    logic          w_busy;
    logic [N-1:0]  w_t;
    logic [N:0]    w_sh;
    logic [N+1:0]  w_dif;
    logic [N-1:0]  w_red;

    assign s_axis_tready = (r_state == S_LOAD);
    wire w_in = s_axis_tvalid && s_axis_tready;

    // reduce base by shifting it in msb first: x = 2x + bit mod m
    always_comb begin
        w_sh  = {r_x, r_b[N-1]};
        w_dif = {1'b0, w_sh} - {2'b00, r_m};
        w_red = w_dif[N+1] ? w_sh[N-1:0] : w_dif[N-1:0];
    end

    assign w_cmd.start     = r_mstart;
    assign w_cmd.sel_src_x = (r_state == S_SQR);

    mexp_mulmod #(.N(N)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_cmd.start),
        .i_a(w_cmd.sel_src_x ? r_x : r_acc), .i_b(r_x), .i_m(r_m),
        .o_busy(w_busy), .o_t(w_t)
    );

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_acc[DATA_W-1:0];
    assign m_axis_tuser  = r_err;
    assign m_axis_tlast  = (r_cnt == CW'(WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_mstart <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            case (r_state)
                S_LOAD: if (w_in) begin
                    if (r_cnt < CW'(WORDS)) begin
                        r_b[r_cnt[CW-1:0]*DATA_W +: DATA_W] <= s_axis_tdata[31:0];
                        r_e[r_cnt*DATA_W +: DATA_W] <= s_axis_tdata[63:32];
                        r_m[r_cnt*DATA_W +: DATA_W] <= s_axis_tdata[95:64];
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        r_x    <= '0;
                        r_bits <= BW'(N);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_bits == BW'(N) && r_cnt != CW'(WORDS)) begin
                        // clear words past the supplied count, one per cycle
                        r_b[r_cnt*DATA_W +: DATA_W] <= '0;
                        r_e[r_cnt*DATA_W +: DATA_W] <= '0;
                        r_m[r_cnt*DATA_W +: DATA_W] <= '0;
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_bits == BW'(N) && r_m == '0) begin
                        r_err <= 1'b1;
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_state <= S_OUT;
                    end else if (r_bits != '0) begin
                        r_x    <= w_red;
                        r_b    <= r_b << 1;
                        r_bits <= r_bits - 1'b1;
                    end else begin
                        r_err  <= 1'b0;
                        r_acc  <= (r_m == N'(1)) ? '0 : N'(1);
                        r_bits <= BW'(N);
                        r_state <= S_WAIT;
                        r_wait_sqr <= 1'b1;
                    end
                end
                S_WAIT: begin
                    if (r_wait_sqr) begin
                        // pick next step for bit e[0]
                        if (r_bits == '0) begin
                            r_cnt <= '0;
                            r_state <= S_OUT;
                        end else if (r_e[0]) begin
                            r_mstart <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_mstart <= 1'b1;
                            r_state <= S_SQR;
                        end
                    end
                    r_wait_sqr <= 1'b1;
                end
                S_MUL: if (!r_mstart && !w_busy) begin
                    r_acc <= w_t;
                    r_mstart <= 1'b1;
                    r_state <= S_SQR;
                end
                S_SQR: if (!r_mstart && !w_busy) begin
                    r_x    <= w_t;
                    r_e    <= r_e >> 1;
                    r_bits <= r_bits - 1'b1;
                    r_state <= S_WAIT;
                end
                S_OUT: if (m_axis_tready) begin
                    r_acc <= r_acc >> DATA_W;
                    if (m_axis_tlast) begin
                        r_cnt <= '0;
                        r_state <= S_LOAD;
                    end else r_cnt <= r_cnt + 1'b1;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_in_busy, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid, "in and out overlap")
    `ASSERT_NEVER(a_err_data, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser && (m_axis_tdata != '0), "error word nonzero")
    `ASSERT_IMPL(a_last_back, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready, "no return to load")
endmodule
`default_nettype wire

>>> hw/rtl/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: t = a*b mod m, one bit of a per step.
`default_nettype none
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int unsigned N = WORDS_DEF * DATA_W
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire [N-1:0] i_a,
    input  wire [N-1:0] i_b,
    input  wire [N-1:0] i_m,
    output logic        o_busy,
    output logic [N-1:0] o_t
);
    localparam int unsigned CW = $clog2(N + 1);
    logic [N-1:0]  r_a, r_t, n_t;
    logic [CW-1:0] r_cnt;
    logic          r_phase;   // 0 = shift, 1 = add
    logic [N:0]    w_sum;
    logic [N+1:0]  w_dif;

    always_comb begin
        if (!r_phase) w_sum = {r_t, 1'b0};
        else          w_sum = {1'b0, r_t} + {1'b0, i_b};
        w_dif = {1'b0, w_sum} - {2'b00, i_m};
        n_t = w_dif[N+1] ? w_sum[N-1:0] : w_dif[N-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            o_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_cnt   <= CW'(N);
            r_a     <= i_a;
            r_t     <= '0;
        end else if (o_busy) begin
            if (!r_phase) begin
                r_t <= n_t;
                if (r_a[N-1]) r_phase <= 1'b1;
                else begin
                    r_a   <= r_a << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) o_busy <= 1'b0;
                end
            end else begin
                r_t     <= n_t;
                r_phase <= 1'b0;
                r_a     <= r_a << 1;
                r_cnt   <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) o_busy <= 1'b0;
            end
        end
    end
    assign o_t = r_t;
endmodule
`default_nettype wire
